// File: rtl/core/lpdsr_pkg.sv
`timescale 1ns / 1ps
package lpdsr_pkg;

  localparam int RING_DEPTH_DEF = 64;
  localparam int LINE_CAP_DEF   = 32;
  localparam int VAL_W          = 32;
  localparam int TIME_W         = 64;

  localparam logic [1:0] ACT_BYTE   = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_SELECT = 2'd2;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_VT    = 8'h0B;
  localparam logic [7:0] CHR_FF    = 8'h0C;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_RDATA,
    ST_WR0,
    ST_WR1
  } lpdsr_state_t;

  typedef enum logic {
    PS_IDLE,
    PS_SCAN
  } lpdsr_pstate_t;

  typedef enum logic [1:0] {
    TK_SKIP,
    TK_SIGN,
    TK_DIGIT
  } lpdsr_tok_t;

  // Parser status as seen by the ring control.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic             ok;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } lpdsr_parse_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_NL) ||
           (c == CHR_VT) || (c == CHR_FF) || (c == CHR_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHR_ZERO) && (c <= CHR_NINE);
  endfunction

endpackage

// File: rtl/core/line_parsed_dual_sample_ring_unit.sv
`timescale 1ns / 1ps
// Two-channel sample ring fed by a serial line parser.
// Input channel (in_valid/in_ready): each beat carries an action. A byte beat
// adds a character to the current line; a newline, or a byte arriving while
// LINE_CAPACITY-1 characters are held, closes the line and starts the parse.
// A read beat pops the oldest sample of the selected channel; a select beat
// picks the channel and empties its ring. Only read beats give a result beat.
// Output channel (out_valid/out_ready): one beat per read, status 0 when empty.
// Flow: a stored byte, a select or an ignored action leaves the unit ready,
// and the next beat is taken in the following cycle. A read waits in ST_READ
// for a free output register; an empty ring gives its result there, while a
// found entry is read from the memory and given in ST_RDATA. Closing a line
// takes the character scan, one stored character per cycle over the single
// read port of the line store, then, if the parse succeeds, ST_WR0 and ST_WR1
// write both channels through the one write port of the sample memory; no
// beat is taken meanwhile. A stalled receiver holds the result in the output
// register; other beats go on, but a further read waits for it and holds them.
// Reset clears the line, both ring pointers and the channel choice; the
// sample memory needs no clearing pass.
module line_parsed_dual_sample_ring_unit #(
  parameter int RING_DEPTH    = lpdsr_pkg::RING_DEPTH_DEF,
  parameter int LINE_CAPACITY = lpdsr_pkg::LINE_CAP_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_action,
  input  logic [7:0]                           in_rx_byte,
  input  logic [lpdsr_pkg::TIME_W-1:0]         in_now_seconds,
  input  logic                                 in_channel,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_read_status,
  output logic [lpdsr_pkg::TIME_W-1:0]         out_read_time,
  output logic signed [lpdsr_pkg::VAL_W-1:0]   out_read_value
);

  localparam int PW        = $clog2(RING_DEPTH);
  localparam int MEM_DEPTH = 2 << PW;
  localparam int ENT_W     = lpdsr_pkg::TIME_W + lpdsr_pkg::VAL_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  lpdsr_pkg::lpdsr_state_t st_r, st_nxt;
  lpdsr_pkg::lpdsr_parse_t pstat;

  logic [ENT_W-1:0] ring_mem [MEM_DEPTH];
  logic [ENT_W-1:0] rd_data_r;

  logic [PW-1:0] wp_r [2];
  logic [PW-1:0] wp_nxt [2];
  logic [PW-1:0] rp_r [2];
  logic [PW-1:0] rp_nxt [2];
  logic          chosen_r, chosen_nxt;
  logic [lpdsr_pkg::TIME_W-1:0] now_r;

  logic                        out_valid_r, out_valid_nxt;
  logic                        status_r, status_nxt;
  logic [lpdsr_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [lpdsr_pkg::VAL_W-1:0]  value_r, value_nxt;

  logic             in_fire;
  logic             byte_beat;
  logic             ring_empty;
  logic             mem_we;
  logic             mem_re;
  logic [PW:0]      mem_waddr;
  logic [PW:0]      mem_raddr;
  logic [ENT_W-1:0] mem_wdata;

  assign in_ready   = (st_r == lpdsr_pkg::ST_IDLE) && !pstat.busy && !pstat.done;
  assign in_fire    = in_valid && in_ready;
  assign byte_beat  = in_fire && (in_action == lpdsr_pkg::ACT_BYTE);
  assign ring_empty = (rp_r[chosen_r] == wp_r[chosen_r]);

  lpdsr_parser #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(byte_beat),
    .rx_byte   (in_rx_byte),
    .status    (pstat)
  );

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      lpdsr_pkg::ST_IDLE: begin
        priority if (pstat.done && pstat.ok) begin
          st_nxt = lpdsr_pkg::ST_WR0;
        end else if (in_fire && (in_action == lpdsr_pkg::ACT_READ)) begin
          st_nxt = lpdsr_pkg::ST_READ;
        end
      end
      lpdsr_pkg::ST_READ: begin
        if (!out_valid_r) begin
          st_nxt = ring_empty ? lpdsr_pkg::ST_IDLE : lpdsr_pkg::ST_RDATA;
        end
      end
      lpdsr_pkg::ST_RDATA: st_nxt = lpdsr_pkg::ST_IDLE;
      lpdsr_pkg::ST_WR0:   st_nxt = lpdsr_pkg::ST_WR1;
      lpdsr_pkg::ST_WR1:   st_nxt = lpdsr_pkg::ST_IDLE;
      default:             st_nxt = lpdsr_pkg::ST_IDLE;
    endcase
  end

  // Memory control, pointers and the output register.
  always_comb begin
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    chosen_nxt    = chosen_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = {1'b0, wp_r[0]};
    mem_wdata     = {now_r, pstat.a};
    mem_raddr     = {chosen_r, rp_r[chosen_r]};
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    time_nxt      = time_r;
    value_nxt     = value_r;
    unique case (st_r)
      lpdsr_pkg::ST_IDLE: begin
        if (in_fire && (in_action == lpdsr_pkg::ACT_SELECT)) begin
          chosen_nxt         = in_channel;
          rp_nxt[in_channel] = wp_r[in_channel];
        end
      end
      lpdsr_pkg::ST_READ: begin
        // Wait for a free output register; an empty ring gives its result here, else the entry is read for ST_RDATA.
        if (!out_valid_r) begin
          if (ring_empty) begin
            out_valid_nxt = 1'b1;
            status_nxt    = 1'b0;
            time_nxt      = '0;
            value_nxt     = '0;
          end else begin
            mem_re           = 1'b1;
            rp_nxt[chosen_r] = ptr_inc(rp_r[chosen_r]);
          end
        end
      end
      lpdsr_pkg::ST_RDATA: begin
        out_valid_nxt = 1'b1;
        status_nxt    = 1'b1;
        time_nxt      = rd_data_r[ENT_W-1 -: lpdsr_pkg::TIME_W];
        value_nxt     = rd_data_r[lpdsr_pkg::VAL_W-1:0];
      end
      lpdsr_pkg::ST_WR0: begin
        mem_we    = 1'b1;
        mem_waddr = {1'b0, wp_r[0]};
        mem_wdata = {now_r, pstat.a};
      end
      lpdsr_pkg::ST_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = {1'b1, wp_r[1]};
        mem_wdata = {now_r, pstat.b};
        wp_nxt[0] = ptr_inc(wp_r[0]);
        wp_nxt[1] = ptr_inc(wp_r[1]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= ring_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= lpdsr_pkg::ST_IDLE;
      wp_r[0]     <= '0;
      wp_r[1]     <= '0;
      rp_r[0]     <= '0;
      rp_r[1]     <= '0;
      chosen_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      chosen_r    <= chosen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_beat) begin
      now_r <= in_now_seconds;
    end
    status_r <= status_nxt;
    time_r   <= time_nxt;
    value_r  <= value_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_status = status_r;
  assign out_read_time   = time_r;
  assign out_read_value  = value_r;

endmodule

// File: rtl/core/lpdsr_parser.sv
`timescale 1ns / 1ps
module lpdsr_parser #(
  parameter int LINE_CAPACITY = lpdsr_pkg::LINE_CAP_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    byte_valid,
  input  logic [7:0]              rx_byte,
  output lpdsr_pkg::lpdsr_parse_t status
);

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam logic [AW-1:0] FILL_LIMIT = AW'(LINE_CAPACITY - 1);

  logic [7:0] line_mem [LINE_CAPACITY];
  logic [7:0] rdata_r;

  lpdsr_pkg::lpdsr_pstate_t st_r, st_nxt;
  lpdsr_pkg::lpdsr_tok_t    tok_r, tok_nxt;

  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] len_r, len_nxt;
  logic [AW-1:0] issue_r, issue_nxt;
  logic          rv_r, rv_nxt;
  logic          second_r, second_nxt;
  logic          neg_r, neg_nxt;
  logic          done_r, done_nxt;
  logic          ok_r, ok_nxt;
  logic [lpdsr_pkg::VAL_W-1:0] acc_r, acc_nxt;
  logic [lpdsr_pkg::VAL_W-1:0] a_r, a_nxt;
  logic [lpdsr_pkg::VAL_W-1:0] b_r, b_nxt;

  logic                        line_end;
  logic                        store;
  logic                        issue;
  logic [3:0]                  digit;
  logic [7:0]                  digit_full;
  logic [lpdsr_pkg::VAL_W-1:0] acc_step;
  logic [lpdsr_pkg::VAL_W-1:0] acc_signed;

  assign line_end   = byte_valid && ((rx_byte == lpdsr_pkg::CHR_NL) || (fill_r >= FILL_LIMIT));
  assign store      = byte_valid && !line_end;
  assign issue      = (st_r == lpdsr_pkg::PS_SCAN) && (issue_r != len_r);
  assign digit_full = rdata_r - lpdsr_pkg::CHR_ZERO;
  assign digit      = digit_full[3:0];
  assign acc_step   = (acc_r << 3) + (acc_r << 1) + lpdsr_pkg::VAL_W'(digit);
  assign acc_signed = neg_r ? (lpdsr_pkg::VAL_W'(0) - acc_r) : acc_r;

  // Line store: one write port for arriving characters, one read port for the scan.
  always_ff @(posedge clk) begin
    if (store) begin
      line_mem[fill_r] <= rx_byte;
    end
    if (issue) begin
      rdata_r <= line_mem[issue_r];
    end
  end

  // Next state of the scan sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      lpdsr_pkg::PS_IDLE: begin
        if (line_end) begin
          st_nxt = lpdsr_pkg::PS_SCAN;
        end
      end
      lpdsr_pkg::PS_SCAN: begin
        if (done_nxt) begin
          st_nxt = lpdsr_pkg::PS_IDLE;
        end
      end
      default: st_nxt = lpdsr_pkg::PS_IDLE;
    endcase
  end

  // Datapath of line filling and of the scan: reads run one character ahead of evaluation.
  always_comb begin
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    issue_nxt  = issue_r;
    rv_nxt     = 1'b0;
    tok_nxt    = tok_r;
    second_nxt = second_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    done_nxt   = 1'b0;
    ok_nxt     = ok_r;
    unique case (st_r)
      lpdsr_pkg::PS_IDLE: begin
        if (line_end) begin
          len_nxt    = fill_r;
          fill_nxt   = '0;
          issue_nxt  = '0;
          tok_nxt    = lpdsr_pkg::TK_SKIP;
          second_nxt = 1'b0;
          neg_nxt    = 1'b0;
        end else if (store) begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      lpdsr_pkg::PS_SCAN: begin
        rv_nxt = issue;
        if (issue) begin
          issue_nxt = issue_r + 1'b1;
        end
        if (rv_r && (rdata_r != lpdsr_pkg::CHR_NUL)) begin
          unique case (tok_r)
            lpdsr_pkg::TK_SKIP: begin
              priority if (lpdsr_pkg::is_blank(rdata_r)) begin
                tok_nxt = lpdsr_pkg::TK_SKIP;
              end else if (rdata_r == lpdsr_pkg::CHR_MINUS) begin
                neg_nxt = 1'b1;
                tok_nxt = lpdsr_pkg::TK_SIGN;
              end else if (lpdsr_pkg::is_digit(rdata_r)) begin
                acc_nxt = lpdsr_pkg::VAL_W'(digit);
                tok_nxt = lpdsr_pkg::TK_DIGIT;
              end else begin
                done_nxt = 1'b1;
                ok_nxt   = 1'b0;
              end
            end
            lpdsr_pkg::TK_SIGN: begin
              if (lpdsr_pkg::is_digit(rdata_r)) begin
                acc_nxt = lpdsr_pkg::VAL_W'(digit);
                tok_nxt = lpdsr_pkg::TK_DIGIT;
              end else begin
                done_nxt = 1'b1;
                ok_nxt   = 1'b0;
              end
            end
            lpdsr_pkg::TK_DIGIT: begin
              priority if (lpdsr_pkg::is_digit(rdata_r)) begin
                acc_nxt = acc_step;
              end else if (second_r) begin
                // Trailing text after the second number is ignored.
                done_nxt = 1'b1;
                ok_nxt   = 1'b1;
                b_nxt    = acc_signed;
              end else if (rdata_r == lpdsr_pkg::CHR_COMMA) begin
                a_nxt      = acc_signed;
                second_nxt = 1'b1;
                neg_nxt    = 1'b0;
                tok_nxt    = lpdsr_pkg::TK_SKIP;
              end else begin
                done_nxt = 1'b1;
                ok_nxt   = 1'b0;
              end
            end
            default: begin
              done_nxt = 1'b1;
              ok_nxt   = 1'b0;
            end
          endcase
        end else if (rv_r || (issue_r == len_r)) begin
          // End of text: either a zero byte or every stored character seen.
          done_nxt = 1'b1;
          ok_nxt   = second_r && (tok_r == lpdsr_pkg::TK_DIGIT);
          b_nxt    = acc_signed;
        end
      end
      default: begin
        done_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= lpdsr_pkg::PS_IDLE;
      fill_r <= '0;
      rv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      rv_r   <= rv_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    issue_r  <= issue_nxt;
    tok_r    <= tok_nxt;
    second_r <= second_nxt;
    neg_r    <= neg_nxt;
    acc_r    <= acc_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    ok_r     <= ok_nxt;
  end

  assign status.busy = (st_r == lpdsr_pkg::PS_SCAN);
  assign status.done = done_r;
  assign status.ok   = ok_r;
  assign status.a    = a_r;
  assign status.b    = b_r;

endmodule
